[sv/scws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scws_pkg
// Shared constants, register codes and the scan tag type of the spike count
// winner select block.
// ----------------------------------------------------------------------------
package scws_pkg;

    // Default sizes of the counter table.
    localparam int DEF_MAX_GROUPS = 16;
    localparam int DEF_MAX_UNITS  = 16;
    localparam int DEF_COUNT_BITS = 16;

    // Group and unit fields are four bits wide, so at most 16 of each are used.
    localparam int FIELD_LIMIT = 16;

    // Configuration register indexes.
    localparam logic CFG_GROUPS_IN_USE = 1'b0;
    localparam logic CFG_UNITS_IN_USE  = 1'b1;

    // Reset value of both configuration registers.
    localparam logic [4:0] REG_RESET = 5'd16;

    // Largest value of the winner count field.
    localparam logic [15:0] RES_COUNT_TOP = 16'hFFFF;

    // Tag that travels with each counter read during a check sweep.
    typedef struct packed {
        logic       first;   // first unit of a group
        logic       in_use;  // entry is inside the groups and units in use
        logic       emit;    // last unit of a group in use: give a result
        logic       last;    // this group is the last one in use
        logic [3:0] grp;     // group number of the entry
        logic [3:0] unit;    // unit number of the entry
    } t_scan_tag;

    // Clamp a register value to the range 1 .. limit.
    function automatic logic [4:0] clamp_use(input logic [4:0] v, input logic [4:0] limit);
        logic [4:0] res;
        if (v == 5'd0) begin
            res = 5'd1;
        end else if (v > limit) begin
            res = limit;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

[sv/scws_counter_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scws_counter_ram
// Counter table: one write port and one read port with registered read data.
// A read and a write of the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
module scws_counter_ram #(
    parameter int AW         = 8,
    parameter int COUNT_BITS = scws_pkg::DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [COUNT_BITS-1:0] o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [COUNT_BITS-1:0] i_wr_data
);

    localparam int DEPTH = 1 << AW;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;

    // Synchronous read, read data held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/scws_winner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scws_winner
// Compare stage of the check sweep: tracks the greatest count of each group
// as the counters stream out of the table, and holds each group result in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module scws_winner #(
    parameter int COUNT_BITS = scws_pkg::DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_issue,
    input  scws_pkg::t_scan_tag   i_tag,
    input  logic [COUNT_BITS-1:0] i_rd_data,
    output logic                  o_busy,
    output logic                  o_stall,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [31:0]           o_m_tdata,  // result_group, has_winner, winner_unit,
                                              // winner_count, zero fill
    output logic                  o_m_tlast   // last_result
);

    localparam int WB = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic                  r_cmp_vld;
    logic                  n_cmp_vld;
    scws_pkg::t_scan_tag   r_tag;
    logic [COUNT_BITS-1:0] r_best;
    logic [COUNT_BITS-1:0] n_best;
    logic [3:0]            r_best_unit;
    logic [3:0]            n_best_unit;
    logic                  r_found;
    logic                  n_found;
    logic                  r_out_vld;
    logic                  n_out_vld;
    logic [3:0]            r_out_grp;
    logic                  r_out_has;
    logic [3:0]            r_out_unit;
    logic [15:0]           r_out_count;
    logic                  r_out_last;
    logic [COUNT_BITS-1:0] w_cur_best;
    logic                  w_upd;
    logic                  w_consume;
    logic [WB-1:0]         w_best_wide;
    logic [15:0]           w_best_sat;

    // The stage waits when a group result is due and the output word is still held.
    assign o_stall   = r_cmp_vld && r_tag.emit && r_out_vld && !i_m_tready;
    assign w_consume = r_cmp_vld && !o_stall;
    assign o_busy    = r_cmp_vld;

    // Running maximum; only a strictly greater count replaces the winner.
    always_comb begin
        w_cur_best  = r_tag.first ? '0 : r_best;
        w_upd       = r_tag.in_use && (i_rd_data > w_cur_best);
        n_best      = w_upd ? i_rd_data : w_cur_best;
        n_best_unit = w_upd ? r_tag.unit : (r_tag.first ? 4'd0 : r_best_unit);
        n_found     = w_upd || (!r_tag.first && r_found);
        w_best_wide = WB'(n_best);
        w_best_sat  = (w_best_wide > WB'(scws_pkg::RES_COUNT_TOP)) ?
                      scws_pkg::RES_COUNT_TOP : w_best_wide[15:0];
    end

    // Valid of the compare stage and of the output word.
    always_comb begin
        n_cmp_vld = i_issue || o_stall;
        n_out_vld = r_out_vld && !i_m_tready;
        if (w_consume && r_tag.emit) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers of the compare stage and the output word.
    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_tag <= i_tag;
        end
        if (w_consume) begin
            r_best      <= n_best;
            r_best_unit <= n_best_unit;
            r_found     <= n_found;
            if (r_tag.emit) begin
                r_out_grp   <= r_tag.grp;
                r_out_has   <= n_found;
                r_out_unit  <= n_best_unit;
                r_out_count <= w_best_sat;
                r_out_last  <= r_tag.last;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0, r_out_count, r_out_unit, r_out_has, r_out_grp};
    assign o_m_tlast  = r_out_last;

endmodule

[sv/spike_count_winner_select_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spike_count_winner_select_core
// Table of saturating spike counters with a winner-take-all check and clear.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on the slave stream. tuser is the kind: 0 is a spike,
// 1 is a check. A spike with a positive value adds one to the counter of its
// group and unit, saturating at the top count. Spikes are taken one per cycle;
// each is a read, increment and write-back of the counter table, with the
// previous write forwarded when two spikes hit the same counter back to back.
// A check walks the whole table, one counter per cycle through the single
// read port, clears every counter, and gives one result word per group in use
// on the master stream, tlast set on the last group. The first result leaves
// once the sweep has read the last unit slot of group 0, and a check holds
// off input until the sweep is done and the compare stage is empty.
// When the receiver stalls, the sweep waits at the next group boundary.
// After reset a clearing pass zeroes the whole table while the input stays
// not ready; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module spike_count_winner_select_core #(
    parameter int MAX_GROUPS = scws_pkg::DEF_MAX_GROUPS,
    parameter int MAX_UNITS  = scws_pkg::DEF_MAX_UNITS,
    parameter int COUNT_BITS = scws_pkg::DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // group_index, unit_index, spike_value
    input  logic        i_s_tuser,   // kind
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // result_group, has_winner, winner_unit,
                                     // winner_count, zero fill
    output logic        o_m_tlast    // last_result
);

    localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int UW  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int AW  = GW + UW;
    localparam int GCW = (GW > 5) ? GW : 5;
    localparam int UCW = (UW > 5) ? UW : 5;
    localparam int GRP_LIMIT = (MAX_GROUPS < scws_pkg::FIELD_LIMIT) ?
                               MAX_GROUPS : scws_pkg::FIELD_LIMIT;
    localparam int UNIT_LIMIT = (MAX_UNITS < scws_pkg::FIELD_LIMIT) ?
                                MAX_UNITS : scws_pkg::FIELD_LIMIT;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [AW-1:0]         r_scan_addr;
    logic [AW-1:0]         n_scan_addr;
    logic [4:0]            r_groups;
    logic [4:0]            r_units;
    logic [4:0]            w_ng;
    logic [4:0]            w_nu;
    logic                  w_s_accept;
    logic [3:0]            w_grp;
    logic [3:0]            w_unit;
    logic signed [7:0]     w_spike_value;
    logic                  w_counts;
    logic                  r_a_vld;
    logic [AW-1:0]         r_a_addr;
    logic                  r_w_vld;
    logic [AW-1:0]         r_w_addr;
    logic [COUNT_BITS-1:0] r_w_data;
    logic [COUNT_BITS-1:0] w_old;
    logic [COUNT_BITS-1:0] w_new;
    logic [GW-1:0]         w_scan_g;
    logic [UW-1:0]         w_scan_u;
    logic                  w_issue;
    logic                  w_stall;
    logic                  w_cmp_busy;
    scws_pkg::t_scan_tag   w_tag;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [COUNT_BITS-1:0] w_rd_data;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [COUNT_BITS-1:0] w_wr_data;

    // Configuration registers and their clamped values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups <= scws_pkg::REG_RESET;
            r_units  <= scws_pkg::REG_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                scws_pkg::CFG_GROUPS_IN_USE: r_groups <= i_cfg_data;
                scws_pkg::CFG_UNITS_IN_USE:  r_units  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_ng = scws_pkg::clamp_use(r_groups, 5'(GRP_LIMIT));
    assign w_nu = scws_pkg::clamp_use(r_units, 5'(UNIT_LIMIT));

    // Input word decode; a spike counts when positive and inside the table in use.
    assign o_s_tready    = (r_state == ST_IDLE);
    assign w_s_accept    = i_s_tvalid && o_s_tready;
    assign w_grp         = i_s_tdata[3:0];
    assign w_unit        = i_s_tdata[7:4];
    assign w_spike_value = i_s_tdata[15:8];
    assign w_counts      = !i_s_tuser && (w_spike_value > 8'sd0) &&
                           ({1'b0, w_grp} < w_ng) && ({1'b0, w_unit} < w_nu);

    // Spike pipeline: read on accept, increment and write back in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_w_vld <= 1'b0;
        end else begin
            r_a_vld <= w_s_accept && w_counts;
            r_w_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_a_addr <= {GW'(w_grp), UW'(w_unit)};
        end
        if (r_a_vld) begin
            r_w_addr <= r_a_addr;
            r_w_data <= w_new;
        end
    end

    // The previous write lands in the same edge as this read, so forward it.
    assign w_old = (r_w_vld && (r_w_addr == r_a_addr)) ? r_w_data : w_rd_data;
    assign w_new = (w_old == COUNT_TOP) ? w_old : w_old + COUNT_BITS'(1);

    // Sweep address split and tag for the compare stage.
    assign w_scan_g = r_scan_addr[AW-1:UW];
    assign w_scan_u = r_scan_addr[UW-1:0];

    always_comb begin
        w_tag.first  = (w_scan_u == '0);
        w_tag.in_use = (GCW'(w_scan_g) < GCW'(w_ng)) && (UCW'(w_scan_u) < UCW'(w_nu));
        w_tag.emit   = (&w_scan_u) && (GCW'(w_scan_g) < GCW'(w_ng));
        w_tag.last   = (GCW'(w_scan_g) == GCW'(w_ng) - GCW'(1));
        w_tag.grp    = 4'(w_scan_g);
        w_tag.unit   = 4'(w_scan_u);
    end

    assign w_issue = (r_state == ST_SCAN) && !w_stall;

    // Sequencer: clearing pass after reset, idle, sweep on a check, drain.
    always_comb begin
        n_state     = r_state;
        n_scan_addr = r_scan_addr;
        unique case (r_state)
            ST_CLEAR: begin
                n_scan_addr = r_scan_addr + AW'(1);
                if (&r_scan_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_scan_addr = '0;
                if (w_s_accept && i_s_tuser) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_issue) begin
                    n_scan_addr = r_scan_addr + AW'(1);
                    if (&r_scan_addr) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!w_cmp_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_scan_addr <= '0;
        end else begin
            r_state     <= n_state;
            r_scan_addr <= n_scan_addr;
        end
    end

    // Memory port selection; the sweep reads each counter and zeroes it.
    always_comb begin
        w_rd_en   = w_issue || (w_s_accept && w_counts);
        w_rd_addr = w_issue ? r_scan_addr : {GW'(w_grp), UW'(w_unit)};
        w_wr_en   = r_a_vld || w_issue || (r_state == ST_CLEAR);
        w_wr_addr = r_a_vld ? r_a_addr : r_scan_addr;
        w_wr_data = r_a_vld ? w_new : '0;
    end

    scws_counter_ram #(
        .AW         (AW),
        .COUNT_BITS (COUNT_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    scws_winner #(
        .COUNT_BITS (COUNT_BITS)
    ) u_winner (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_issue    (w_issue),
        .i_tag      (w_tag),
        .i_rd_data  (w_rd_data),
        .o_busy     (w_cmp_busy),
        .o_stall    (w_stall),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // No spike write-back may overlap the sweep.
    a_no_spike_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !r_a_vld)
        else $error("spike write-back during check sweep");

    // The compare stage is empty whenever new input is taken.
    a_idle_cmp_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_cmp_busy)
        else $error("compare stage busy while idle");

    // A check word starts the sweep at the first counter.
    a_check_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_accept && i_s_tuser) |=> ((r_state == ST_SCAN) && (r_scan_addr == '0)))
        else $error("check did not start the sweep");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spike count winner select core. A queue of
// spike and check words feeds a bursty stream driver, a local copy of the
// counter table predicts the winner words of every check, and a monitor
// compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    // Word kinds carried on tuser.
    localparam logic KIND_SPIKE = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    localparam logic [15:0] COUNT_TOP   = 16'hFFFF;
    localparam int          SETTLE_CYC  = 320;   // one full sweep plus margin
    localparam int          HOLD_CYCLES = 600;
    localparam int          RAND_ITEMS  = 195;

    typedef struct packed {
        logic       kind;
        logic [7:0] spk_val;
        logic [3:0] unit_idx;
        logic [3:0] grp_idx;
    } t_spike_word;

    typedef struct packed {
        logic        is_last;
        logic [6:0]  pad;
        logic [15:0] cnt;
        logic [3:0]  unit_idx;
        logic        has_win;
        logic [3:0]  grp_idx;
    } t_winner_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // Bench state.
    t_spike_word  word_q[$];
    t_winner_word winner_q[$];
    logic [15:0]  tally [16][16];
    logic [4:0]   groups_reg = scws_pkg::REG_RESET;
    logic [4:0]   units_reg  = scws_pkg::REG_RESET;
    int           err_cnt = 0;
    bit           in_taken = 1'b0;
    bit           hold_req = 1'b0;
    int           hold_cnt = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_mode = 0;
    int           mode_left = 0;

    spike_count_winner_select_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Number of groups or units actually scanned for a register value.
    function automatic int unsigned in_use(input logic [4:0] v);
        if (v == 5'd0) begin
            return 1;
        end else if (v > 5'd16) begin
            return 16;
        end
        return v;
    endfunction

    // Count one spike word or rank every group in use for a check word.
    task automatic tally_word(input logic kind, input logic [15:0] data);
        int unsigned  ng;
        int unsigned  nu;
        logic [3:0]   g;
        logic [3:0]   u;
        logic [7:0]   sv;
        logic [15:0]  best;
        t_winner_word w;
        ng = in_use(groups_reg);
        nu = in_use(units_reg);
        g  = data[3:0];
        u  = data[7:4];
        sv = data[15:8];
        if (kind == KIND_SPIKE) begin
            if (sv != 8'd0 && !sv[7] && g < ng && u < nu && tally[g][u] != COUNT_TOP) begin
                tally[g][u] = tally[g][u] + 16'd1;
            end
        end else begin
            for (int gi = 0; gi < ng; gi++) begin
                best = '0;
                w = '0;
                w.grp_idx = gi[3:0];
                w.is_last = (gi + 1 == ng);
                for (int ui = 0; ui < nu; ui++) begin
                    if (tally[gi][ui] > best) begin
                        best = tally[gi][ui];
                        w.unit_idx = ui[3:0];
                        w.has_win = 1'b1;
                    end
                end
                w.cnt = best;
                winner_q.push_back(w);
            end
            for (int gi = 0; gi < 16; gi++) begin
                for (int ui = 0; ui < 16; ui++) begin
                    tally[gi][ui] = '0;
                end
            end
        end
    endtask

    // Stream driver: bursts of words separated by random gaps.
    always @(negedge i_clk) begin : drive_proc
        t_spike_word w;
        if (i_rst_n && (!s_tvalid || in_taken)) begin
            in_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (word_q.size() > 0) begin
                w = word_q.pop_front();
                s_tdata  <= {w.spk_val, w.unit_idx, w.grp_idx};
                s_tuser  <= w.kind;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: a long hold-off on request, otherwise a changing stall pattern.
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            m_tready <= 1'b0;
            hold_cnt--;
            if (hold_cnt == 0) begin
                hold_req = 1'b0;
            end
        end else if (hold_req) begin
            hold_cnt = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left  = $urandom_range(8, 64);
                stall_mode = $urandom_range(0, 2);
            end
            mode_left--;
            case (stall_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= $urandom_range(0, 1);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // Monitor: track register writes, predict accepted words, check result words.
    always @(posedge i_clk) begin : mon_proc
        t_winner_word got;
        t_winner_word want;
        if (i_rst_n) begin
            if (cfg_wr_en) begin
                if (cfg_index == scws_pkg::CFG_GROUPS_IN_USE) begin
                    groups_reg = cfg_data;
                end else begin
                    units_reg = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                tally_word(s_tuser, s_tdata);
                in_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata};
                if (winner_q.size() == 0) begin
                    $display("%0t: unexpected result word %h last=%0d", $realtime,
                             m_tdata, m_tlast);
                    err_cnt++;
                end else begin
                    want = winner_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch exp grp=%0d has=%0d unit=%0d cnt=%0d",
                                 $realtime, want.grp_idx, want.has_win, want.unit_idx,
                                 want.cnt, " last=%0d pad=%h", want.is_last, want.pad);
                        $display("%0t:          got grp=%0d has=%0d unit=%0d cnt=%0d",
                                 $realtime, got.grp_idx, got.has_win, got.unit_idx,
                                 got.cnt, " last=%0d pad=%h", got.is_last, got.pad);
                        err_cnt++;
                    end
                end
            end
        end
    end

    task automatic push_spike(input int g, input int u, input logic [7:0] v);
        t_spike_word w;
        w.kind     = KIND_SPIKE;
        w.grp_idx  = g[3:0];
        w.unit_idx = u[3:0];
        w.spk_val  = v;
        word_q.push_back(w);
    endtask

    task automatic push_check();
        t_spike_word w;
        w.kind     = KIND_CHECK;
        w.grp_idx  = $urandom_range(0, 15);
        w.unit_idx = $urandom_range(0, 15);
        w.spk_val  = $urandom_range(0, 255);
        word_q.push_back(w);
    endtask

    // Wait until every word is taken and every result has arrived, then let
    // trailing spikes drain through the pipeline. The test is made just after
    // the falling edge, once the driver's updates have landed.
    task automatic settle();
        do begin
            @(negedge i_clk);
            #1;
        end while (word_q.size() > 0 || s_tvalid || winner_q.size() > 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [0:0] idx, input logic [4:0] v);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [4:0] pick_reg();
        case ($urandom_range(0, 7))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd31;
            4: return 5'd17;
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    // Stimulus.
    initial begin : stim_proc
        int          rnd_items;
        int          n;
        int          r;
        int unsigned ng;
        int unsigned nu;
        int          hot;
        bit          first_phase;
        for (int gi = 0; gi < 16; gi++) begin
            for (int ui = 0; ui < 16; ui++) begin
                tally[gi][ui] = '0;
            end
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset configuration: empty check, value edges,
        // ignored nonpositive values, a tie, and a count left for the clear test.
        push_check();
        push_spike(0, 0, 8'd127);
        push_spike(15, 15, 8'd1);
        push_spike(3, 5, 8'h80);
        push_spike(3, 6, 8'h00);
        push_spike(3, 7, 8'hFF);
        push_spike(2, 9, 8'd5);
        push_spike(2, 9, 8'd5);
        push_spike(2, 4, 8'd64);
        push_spike(2, 4, 8'd64);
        push_check();
        push_spike(12, 3, 8'd1);
        settle();

        // Zero units clamps to one; spikes outside the used area are dropped.
        // This check must also clear the count left in group 12.
        set_reg(scws_pkg::CFG_GROUPS_IN_USE, 5'd2);
        set_reg(scws_pkg::CFG_UNITS_IN_USE, 5'd0);
        push_spike(1, 1, 8'd1);
        push_spike(1, 0, 8'd1);
        push_spike(2, 0, 8'd1);
        push_check();
        settle();

        // Oversized values clamp to sixteen; group 12 must read as empty.
        set_reg(scws_pkg::CFG_GROUPS_IN_USE, 5'd31);
        set_reg(scws_pkg::CFG_UNITS_IN_USE, 5'd17);
        push_check();
        settle();

        // Random phases of mostly in-range spikes with some noise.
        rnd_items = 0;
        first_phase = 1'b1;
        while (rnd_items < RAND_ITEMS) begin
            set_reg(scws_pkg::CFG_GROUPS_IN_USE, pick_reg());
            set_reg(scws_pkg::CFG_UNITS_IN_USE, pick_reg());
            ng  = in_use(groups_reg);
            nu  = in_use(units_reg);
            hot = (nu > 3) ? 2 : nu - 1;
            if (first_phase) begin
                // The receiver stops while two checks lead the phase, so the
                // sweep backs up and the words behind it wait at the input.
                hold_req = 1'b1;
                first_phase = 1'b0;
                push_check();
                push_check();
                rnd_items += 2;
            end
            n = $urandom_range(15, 40);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    push_check();
                end else if (r < 80) begin
                    push_spike($urandom_range(0, ng - 1),
                               $urandom_range(0, 1) ? $urandom_range(0, nu - 1)
                                                    : $urandom_range(0, hot),
                               $urandom_range(1, 127));
                end else begin
                    push_spike($urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 255));
                end
                rnd_items++;
            end
            push_check();
            rnd_items++;
            settle();
        end

        if (err_cnt == 0) begin
            $display("** spike_count_winner_select_core: PASSED **");
        end else begin
            $display("** spike_count_winner_select_core: FAILED **");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #8000000;
        $display("** spike_count_winner_select_core: FAILED **");
        $finish;
    end

endmodule
